// File: design/aeg_pkg.sv
package aeg_pkg;

   // sequencer states, one-hot
   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_SETUP  = 5'b00010,
      S_LAUNCH = 5'b00100,
      S_DIVIDE = 5'b01000,
      S_FINISH = 5'b10000
   } seq_state_type;

   // register map
   localparam int CSR_INDEX_WIDTH = 3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_ATTACK  = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_DECAY   = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_RELEASE = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_SUSTAIN = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_PEAK    = 3'd4;

   // register reset values
   localparam int RESET_ATTACK  = 441;
   localparam int RESET_DECAY   = 4410;
   localparam int RESET_RELEASE = 4410;
   localparam int RESET_SUSTAIN = 58982;
   localparam int RESET_PEAK    = 64881;

   // envelope phase codes
   localparam int PHASE_WIDTH = 2;
   localparam logic [PHASE_WIDTH-1:0] PHASE_ATTACK  = 2'd0;
   localparam logic [PHASE_WIDTH-1:0] PHASE_DECAY   = 2'd1;
   localparam logic [PHASE_WIDTH-1:0] PHASE_SUSTAIN = 2'd2;
   localparam logic [PHASE_WIDTH-1:0] PHASE_RELEASE = 2'd3;

endpackage

// File: design/aeg_if.sv
// request channel: one sample tick
interface aeg_req_if #(
   parameter int TIME_WIDTH = 32
) ();
   logic                  valid;
   logic                  ready;
   logic [TIME_WIDTH-1:0] sample_time;
   logic                  note_on;

   modport source (output valid, output sample_time, output note_on, input ready);
   modport sink   (input valid, input sample_time, input note_on, output ready);
endinterface

// response channel: one envelope value
interface aeg_rsp_if #(
   parameter int LEVEL_WIDTH = 16
) ();
   import aeg_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [LEVEL_WIDTH-1:0] level;
   logic                   active;
   logic [PHASE_WIDTH-1:0] phase;

   modport source (output valid, output level, output active, output phase, input ready);
   modport sink   (input valid, input level, input active, input phase, output ready);
endinterface

// register write channel
interface aeg_csr_if #(
   parameter int DATA_WIDTH = 20
) ();
   import aeg_pkg::*;
   logic                       valid;
   logic                       ready;
   logic [CSR_INDEX_WIDTH-1:0] index;
   logic [DATA_WIDTH-1:0]      data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// File: design/aeg_csr.sv
module aeg_csr #(
   parameter int LEVEL_WIDTH    = 16,
   parameter int DURATION_WIDTH = 20
) (
   input  logic                      clock,
   input  logic                      reset,
   aeg_csr_if.sink                   csr_bus,
   output logic [DURATION_WIDTH-1:0] attack_len,
   output logic [DURATION_WIDTH-1:0] decay_len,
   output logic [DURATION_WIDTH-1:0] release_len,
   output logic [LEVEL_WIDTH-1:0]    sustain_lvl,
   output logic [LEVEL_WIDTH-1:0]    peak_lvl
);
   import aeg_pkg::*;

   logic [DURATION_WIDTH-1:0] attack_ff, attack_in;
   logic [DURATION_WIDTH-1:0] decay_ff, decay_in;
   logic [DURATION_WIDTH-1:0] rel_ff, rel_in;
   logic [LEVEL_WIDTH-1:0]    sustain_ff, sustain_in;
   logic [LEVEL_WIDTH-1:0]    peak_ff, peak_in;

   // the write side is always ready, so every write is taken
   assign csr_bus.ready = 1'b1;

   // register write decode, unknown indexes are dropped
   always_comb begin
      attack_in  = attack_ff;
      decay_in   = decay_ff;
      rel_in     = rel_ff;
      sustain_in = sustain_ff;
      peak_in    = peak_ff;
      if (csr_bus.valid) begin
         unique case (csr_bus.index)
            REG_ATTACK:  attack_in  = csr_bus.data[DURATION_WIDTH-1:0];
            REG_DECAY:   decay_in   = csr_bus.data[DURATION_WIDTH-1:0];
            REG_RELEASE: rel_in     = csr_bus.data[DURATION_WIDTH-1:0];
            REG_SUSTAIN: sustain_in = csr_bus.data[LEVEL_WIDTH-1:0];
            REG_PEAK:    peak_in    = csr_bus.data[LEVEL_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         attack_ff  <= DURATION_WIDTH'(RESET_ATTACK);
         decay_ff   <= DURATION_WIDTH'(RESET_DECAY);
         rel_ff     <= DURATION_WIDTH'(RESET_RELEASE);
         sustain_ff <= LEVEL_WIDTH'(RESET_SUSTAIN);
         peak_ff    <= LEVEL_WIDTH'(RESET_PEAK);
      end else begin
         attack_ff  <= attack_in;
         decay_ff   <= decay_in;
         rel_ff     <= rel_in;
         sustain_ff <= sustain_in;
         peak_ff    <= peak_in;
      end
   end

   assign attack_len  = attack_ff;
   assign decay_len   = decay_ff;
   assign release_len = rel_ff;
   assign sustain_lvl = sustain_ff;
   assign peak_lvl    = peak_ff;

endmodule

// File: design/aeg_div.sv
// scaled ramp unit: quotient = factor * scale / divisor, with factor <= divisor,
// so the quotient fits the scale width; one multiply then one quotient bit a clock
module aeg_div #(
   parameter int LEVEL_WIDTH    = 16,
   parameter int DURATION_WIDTH = 20
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [DURATION_WIDTH-1:0] factor,
   input  logic [LEVEL_WIDTH-1:0]    scale,
   input  logic [DURATION_WIDTH-1:0] divisor,
   output logic                      done,
   output logic [LEVEL_WIDTH-1:0]    quotient
);
   localparam int WORK_WIDTH  = DURATION_WIDTH + LEVEL_WIDTH;
   localparam int COUNT_WIDTH = $clog2(LEVEL_WIDTH + 1);

   logic [WORK_WIDTH-1:0]     work_ff, work_in;
   logic [COUNT_WIDTH-1:0]    count_ff, count_in;
   logic                      busy_ff, busy_in;
   logic [DURATION_WIDTH:0]   trial;
   logic [DURATION_WIDTH:0]   diff;
   logic                      fits;

   // restoring step: partial remainder with the next dividend bit
   assign trial = {work_ff[WORK_WIDTH-1:LEVEL_WIDTH], work_ff[LEVEL_WIDTH-1]};
   assign diff  = trial - {1'b0, divisor};
   assign fits  = trial >= {1'b0, divisor};
   assign done  = busy_ff && (count_ff == COUNT_WIDTH'(1));

   always_comb begin
      work_in  = work_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      if (start) begin
         // product registered before the first step
         work_in  = WORK_WIDTH'(factor) * WORK_WIDTH'(scale);
         count_in = COUNT_WIDTH'(LEVEL_WIDTH);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         work_in  = {fits ? diff[DURATION_WIDTH-1:0] : trial[DURATION_WIDTH-1:0],
                     work_ff[LEVEL_WIDTH-2:0], fits};
         count_in = count_ff - COUNT_WIDTH'(1);
         busy_in  = !done;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         busy_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         busy_ff  <= busy_in;
      end
   end

   // datapath, no reset
   always_ff @(posedge clock) begin
      work_ff <= work_in;
   end

   assign quotient = work_ff[LEVEL_WIDTH-1:0];

endmodule

// File: design/adsr_envelope_generator.sv
// channel  | direction | fields                                | handshake
// req_bus  | in        | sample_time, note_on                  | valid / ready
// rsp_bus  | out       | level, active, phase                  | valid / ready
// csr_bus  | in        | index, data (attack, decay, release,  | valid / ready
//          |           | sustain, peak)                        |
//
// A tick with a computed ramp passes from acceptance through setup, launch,
// divide and finish before the next acceptance: the serial divider yields
// one quotient bit per clock. Flat-level and ramp-end ticks skip the divider.
// Reset is synchronous: registers return to their defaults, the note is idle.
// A result waits in the output register; the sequencer stalls in its last state
// until that register is free, and the request side is ready only when idle.
module adsr_envelope_generator #(
   parameter int TIME_WIDTH     = 32,
   parameter int LEVEL_WIDTH    = 16,
   parameter int DURATION_WIDTH = 20
) (
   input  logic      clock,
   input  logic      reset,
   aeg_req_if.sink   req_bus,
   aeg_rsp_if.source rsp_bus,
   aeg_csr_if.sink   csr_bus
);
   import aeg_pkg::*;

   localparam int CMP_WIDTH = (TIME_WIDTH > DURATION_WIDTH + 1) ? TIME_WIDTH
                                                                 : DURATION_WIDTH + 1;

   // configuration
   logic [DURATION_WIDTH-1:0] attack_len, decay_len, release_len;
   logic [LEVEL_WIDTH-1:0]    sustain_lvl, peak_lvl;

   // sequencer and captured request
   seq_state_type             state_ff, state_in;
   logic [TIME_WIDTH-1:0]     time_ff, time_in;
   logic                      note_on_ff, note_on_in;

   // note tracking
   logic [TIME_WIDTH-1:0]     note_start_ff, note_start_in;
   logic [TIME_WIDTH-1:0]     note_end_ff, note_end_in;
   logic                      start_latched_ff, start_latched_in;
   logic                      end_latched_ff, end_latched_in;
   logic                      idle_ff, idle_in;

   // operation for the ramp unit
   logic [DURATION_WIDTH-1:0] factor_ff, factor_in;
   logic [LEVEL_WIDTH-1:0]    scale_ff, scale_in;
   logic [DURATION_WIDTH-1:0] divisor_ff, divisor_in;
   logic [LEVEL_WIDTH-1:0]    base_ff, base_in;
   logic                      sub_ff, sub_in;
   logic                      direct_ff, direct_in;
   logic [PHASE_WIDTH-1:0]    phase_ff, phase_in;

   // output register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [LEVEL_WIDTH-1:0]    rsp_level_ff, rsp_level_in;
   logic                      rsp_active_ff, rsp_active_in;
   logic [PHASE_WIDTH-1:0]    rsp_phase_ff, rsp_phase_in;

   // setup decode
   logic [TIME_WIDTH-1:0]     start_eff, end_eff;
   logic [TIME_WIDTH-1:0]     held_time, rel_time;
   logic [CMP_WIDTH-1:0]      held_cmp, rel_cmp, attack_cmp, decay_end_cmp, release_cmp;
   logic [DURATION_WIDTH-1:0] decay_step;
   logic                      rising;
   logic [LEVEL_WIDTH-1:0]    span;

   // ramp unit handshake
   logic                      div_start, div_done;
   logic [LEVEL_WIDTH-1:0]    quotient;
   logic [LEVEL_WIDTH-1:0]    level_calc;
   logic                      accept, out_free;

   aeg_csr #(
      .LEVEL_WIDTH    (LEVEL_WIDTH),
      .DURATION_WIDTH (DURATION_WIDTH)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_bus     (csr_bus),
      .attack_len  (attack_len),
      .decay_len   (decay_len),
      .release_len (release_len),
      .sustain_lvl (sustain_lvl),
      .peak_lvl    (peak_lvl)
   );

   aeg_div #(
      .LEVEL_WIDTH    (LEVEL_WIDTH),
      .DURATION_WIDTH (DURATION_WIDTH)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .factor   (factor_ff),
      .scale    (scale_ff),
      .divisor  (divisor_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   assign req_bus.ready = (state_ff == S_IDLE);
   assign accept        = req_bus.valid && (state_ff == S_IDLE);
   assign out_free      = !rsp_valid_ff || rsp_bus.ready;
   assign div_start     = (state_ff == S_LAUNCH);

   // elapsed time since note start or note end
   assign start_eff     = start_latched_ff ? note_start_ff : time_ff;
   assign end_eff       = end_latched_ff ? note_end_ff : time_ff;
   assign held_time     = time_ff - start_eff;
   assign rel_time      = time_ff - end_eff;
   assign held_cmp      = CMP_WIDTH'(held_time);
   assign rel_cmp       = CMP_WIDTH'(rel_time);
   assign attack_cmp    = CMP_WIDTH'(attack_len);
   assign decay_end_cmp = CMP_WIDTH'(attack_len) + CMP_WIDTH'(decay_len);
   assign release_cmp   = CMP_WIDTH'(release_len);
   assign decay_step    = DURATION_WIDTH'(held_cmp - attack_cmp);
   assign rising        = sustain_lvl > peak_lvl;
   assign span          = rising ? sustain_lvl - peak_lvl : peak_lvl - sustain_lvl;

   // final level from the ramp quotient
   assign level_calc = direct_ff ? base_ff : (sub_ff ? base_ff - quotient : base_ff + quotient);

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:   if (accept) state_in = S_SETUP;
         S_SETUP:  state_in = direct_in ? S_FINISH : S_LAUNCH;
         S_LAUNCH: state_in = S_DIVIDE;
         S_DIVIDE: if (div_done) state_in = S_FINISH;
         S_FINISH: if (out_free) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   // capture the request
   always_comb begin
      time_in    = time_ff;
      note_on_in = note_on_ff;
      if (accept) begin
         time_in    = req_bus.sample_time;
         note_on_in = req_bus.note_on;
      end
   end

   // note tracking and ramp selection, taken in the setup cycle
   always_comb begin
      note_start_in    = note_start_ff;
      note_end_in      = note_end_ff;
      start_latched_in = start_latched_ff;
      end_latched_in   = end_latched_ff;
      idle_in          = idle_ff;
      factor_in        = factor_ff;
      scale_in         = scale_ff;
      divisor_in       = divisor_ff;
      base_in          = base_ff;
      sub_in           = sub_ff;
      direct_in        = direct_ff;
      phase_in         = phase_ff;
      if (state_ff == S_SETUP) begin
         factor_in  = held_cmp[DURATION_WIDTH-1:0];
         scale_in   = peak_lvl;
         divisor_in = attack_len;
         base_in    = '0;
         sub_in     = 1'b0;
         direct_in  = 1'b0;
         if (note_on_ff) begin
            note_start_in    = start_eff;
            start_latched_in = 1'b1;
            note_end_in      = '0;
            end_latched_in   = 1'b0;
            idle_in          = 1'b0;
            if (held_cmp <= attack_cmp) begin
               phase_in = PHASE_ATTACK;
               // zero-length attack sits at the peak
               if (attack_len == '0) begin
                  direct_in = 1'b1;
                  base_in   = peak_lvl;
               end
            end else if (held_cmp <= decay_end_cmp) begin
               phase_in   = PHASE_DECAY;
               factor_in  = decay_step;
               scale_in   = span;
               divisor_in = decay_len;
               base_in    = peak_lvl;
               sub_in     = !rising;
            end else begin
               phase_in  = PHASE_SUSTAIN;
               direct_in = 1'b1;
               base_in   = sustain_lvl;
            end
         end else begin
            note_end_in      = end_eff;
            end_latched_in   = 1'b1;
            note_start_in    = '0;
            start_latched_in = 1'b0;
            phase_in         = PHASE_RELEASE;
            if (rel_cmp < release_cmp) begin
               factor_in  = rel_cmp[DURATION_WIDTH-1:0];
               scale_in   = sustain_lvl;
               divisor_in = release_len;
               base_in    = sustain_lvl;
               sub_in     = 1'b1;
            end else begin
               direct_in = 1'b1;
            end
            // envelope goes quiet only strictly past the release end, and only with a nonzero sustain
            if ((sustain_lvl != '0) && (rel_cmp > release_cmp)) begin
               idle_in = 1'b1;
            end
         end
      end
   end

   // output register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_level_in  = rsp_level_ff;
      rsp_active_in = rsp_active_ff;
      rsp_phase_in  = rsp_phase_ff;
      if ((state_ff == S_FINISH) && out_free) begin
         rsp_valid_in  = 1'b1;
         rsp_level_in  = level_calc;
         rsp_active_in = !idle_ff;
         rsp_phase_in  = phase_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         note_start_ff    <= '0;
         note_end_ff      <= '0;
         start_latched_ff <= 1'b0;
         end_latched_ff   <= 1'b0;
         idle_ff          <= 1'b1;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         note_start_ff    <= note_start_in;
         note_end_ff      <= note_end_in;
         start_latched_ff <= start_latched_in;
         end_latched_ff   <= end_latched_in;
         idle_ff          <= idle_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      time_ff       <= time_in;
      note_on_ff    <= note_on_in;
      factor_ff     <= factor_in;
      scale_ff      <= scale_in;
      divisor_ff    <= divisor_in;
      base_ff       <= base_in;
      sub_ff        <= sub_in;
      direct_ff     <= direct_in;
      phase_ff      <= phase_in;
      rsp_level_ff  <= rsp_level_in;
      rsp_active_ff <= rsp_active_in;
      rsp_phase_ff  <= rsp_phase_in;
   end

   assign rsp_bus.valid  = rsp_valid_ff;
   assign rsp_bus.level  = rsp_level_ff;
   assign rsp_bus.active = rsp_active_ff;
   assign rsp_bus.phase  = rsp_phase_ff;

endmodule

// File: design/aeg_checker.sv
module aeg_checker #(
   parameter int LEVEL_WIDTH = 16
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [LEVEL_WIDTH-1:0] rsp_level,
   input logic                   rsp_active,
   input logic [1:0]             rsp_phase
);
   import aeg_pkg::*;

   // a request keeps the block busy through setup and the state after it
   a_busy_after_request: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready ##1 !req_ready)
      else $error("request side ready too soon after a request");

   // a held note always reports a sounding envelope
   a_held_is_active: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_phase != PHASE_RELEASE) |-> rsp_active)
      else $error("held note reported inactive");

   // a new result appears only while requests are blocked
   a_result_while_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("result appeared while idle");

   // stalled result holds
   a_result_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_level)
         && $stable(rsp_active) && $stable(rsp_phase))
      else $error("stalled result changed");

endmodule

bind adsr_envelope_generator aeg_checker #(
   .LEVEL_WIDTH (LEVEL_WIDTH)
) u_aeg_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_bus.valid),
   .req_ready  (req_bus.ready),
   .rsp_valid  (rsp_bus.valid),
   .rsp_ready  (rsp_bus.ready),
   .rsp_level  (rsp_bus.level),
   .rsp_active (rsp_bus.active),
   .rsp_phase  (rsp_bus.phase)
);

// File: tb/tb_top.sv
module tb_top;
   import aeg_pkg::*;

   localparam int  DRAIN_CYCLES    = 32;
   localparam int  HOLD_OFF_CYCLES = 300;
   localparam int  RANDOM_SETTINGS = 12;
   localparam int  TICKS_PER_SETTING = 130;
   localparam longint TIMEOUT      = 64'd10_000_000;

   // indexes past the register map, writes there must change nothing
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_SPARE_FIRST = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_SPARE_LAST  = 3'd7;

   typedef struct packed {
      logic [15:0]            level;
      logic                   active;
      logic [PHASE_WIDTH-1:0] phase;
   } env_result_type;

   typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_type;

   typedef struct packed {
      row_kind_type               kind;
      logic [CSR_INDEX_WIDTH-1:0] index;
      logic [19:0]                data;
      logic [31:0]                t;
      logic                       on;
      logic                       typed;
      env_result_type             want;
   } stim_row_type;

   typedef enum int {RX_STEADY, RX_COIN, RX_PERIODIC, RX_BURSTY} rx_mode_type;

   logic clock = 1'b0;
   logic reset;

   aeg_req_if #(.TIME_WIDTH(32))  req_bus ();
   aeg_rsp_if #(.LEVEL_WIDTH(16)) rsp_bus ();
   aeg_csr_if #(.DATA_WIDTH(20))  csr_bus ();

   adsr_envelope_generator u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // shadow of the envelope registers and note state
   logic [19:0] cfg_attack;
   logic [19:0] cfg_decay;
   logic [19:0] cfg_release;
   logic [15:0] cfg_sustain;
   logic [15:0] cfg_peak;
   logic [31:0] note_t0;
   logic [31:0] release_t0;
   logic        start_seen;
   logic        end_seen;
   logic        silent;

   env_result_type envelope_due[$];
   stim_row_type   stim_rows[$];

   int errors = 0;
   int results_checked = 0;
   int hold_offs_done = 0;
   int hold_offs_asked;
   int ticks_sent;
   int writes_done;
   int settings_loaded;
   int pauses_done;
   int burst_left;
   logic [31:0] t_now;

   // clock
   always #5 clock = ~clock;

   // run limit
   initial begin
      #(TIMEOUT);
      $display("tb_top: errors");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      errors++;
      $display("tb_top: mismatch: %s", msg);
   endtask

   // expected envelope value for one tick, advances the shadow note state
   function automatic env_result_type predict_envelope(input logic [31:0] t, input logic on);
      env_result_type r;
      logic [31:0] since;
      logic [63:0] elapsed;
      logic [63:0] knee;
      logic [63:0] step;
      logic [63:0] q;
      logic [63:0] a_len;
      logic [63:0] d_len;
      logic [63:0] r_len;
      logic [63:0] pk;
      logic [63:0] su;
      a_len    = 64'(cfg_attack);
      d_len    = 64'(cfg_decay);
      r_len    = 64'(cfg_release);
      pk       = 64'(cfg_peak);
      su       = 64'(cfg_sustain);
      r.level  = '0;
      r.phase  = PHASE_RELEASE;
      r.active = 1'b0;
      if (on && !start_seen) begin
         note_t0    = t;
         start_seen = 1'b1;
         silent     = 1'b0;
      end
      if (!on && !end_seen) begin
         release_t0 = t;
         end_seen   = 1'b1;
      end
      if (on) begin
         since   = t - note_t0;
         elapsed = 64'(since);
         knee    = a_len + d_len;
         if (elapsed <= a_len) begin
            r.phase = PHASE_ATTACK;
            if (a_len == '0) begin
               r.level = cfg_peak;
            end else begin
               q = elapsed * pk / a_len;
               r.level = q[15:0];
            end
         end else if (elapsed <= knee) begin
            // decay moves toward sustain, up or down
            step = elapsed - a_len;
            r.phase = PHASE_DECAY;
            if (su <= pk) begin
               q = step * (pk - su) / d_len;
               r.level = cfg_peak - q[15:0];
            end else begin
               q = step * (su - pk) / d_len;
               r.level = cfg_peak + q[15:0];
            end
         end else begin
            r.phase = PHASE_SUSTAIN;
            r.level = cfg_sustain;
         end
         end_seen   = 1'b0;
         release_t0 = '0;
         silent     = 1'b0;
      end else begin
         // release always ramps from sustain, not from the current level
         since   = t - release_t0;
         elapsed = 64'(since);
         r.phase = PHASE_RELEASE;
         if (elapsed < r_len) begin
            q = elapsed * su / r_len;
            r.level = cfg_sustain - q[15:0];
         end
         if (su != '0 && elapsed > r_len) silent = 1'b1;
         start_seen = 1'b0;
         note_t0    = '0;
      end
      r.active = !silent;
      return r;
   endfunction

   // one tick request, sender may idle between bursts
   task automatic send_tick(input logic [31:0] t, input logic on, input logic typed,
                            input env_result_type want);
      int gap;
      env_result_type pred;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 30);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
         if (gap != 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_bus.valid       <= 1'b1;
      req_bus.sample_time <= t;
      req_bus.note_on     <= on;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      pred = predict_envelope(t, on);
      envelope_due.push_back(typed ? want : pred);
      ticks_sent++;
      @(negedge clock);
   endtask

   // stop offering and wait until the block has nothing left in flight
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (envelope_due.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // one register write, valid is left high for a following write
   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] idx, input logic [19:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      case (idx)
         REG_ATTACK:  cfg_attack  = value;
         REG_DECAY:   cfg_decay   = value;
         REG_RELEASE: cfg_release = value;
         REG_SUSTAIN: cfg_sustain = value[15:0];
         REG_PEAK:    cfg_peak    = value[15:0];
         default: ;
      endcase
      writes_done++;
      @(negedge clock);
   endtask

   function automatic logic [19:0] pick_duration();
      case ($urandom_range(0, 9))
         0:             return '0;
         1:             return '1;
         2, 3, 4, 5, 6: return 20'($urandom_range(1, 64));
         default:       return 20'($urandom);
      endcase
   endfunction

   // level data with random upper bits, which the register drops
   function automatic logic [19:0] pick_level();
      logic [19:0] v;
      v = 20'($urandom);
      case ($urandom_range(0, 4))
         0:       v[15:0] = '0;
         1:       v[15:0] = '1;
         default: ;
      endcase
      return v;
   endfunction

   task automatic load_random_setting();
      logic [CSR_INDEX_WIDTH-1:0] idx;
      logic [19:0] junk;
      wait_drained();
      write_reg(REG_ATTACK,  pick_duration());
      write_reg(REG_DECAY,   pick_duration());
      write_reg(REG_RELEASE, pick_duration());
      write_reg(REG_SUSTAIN, pick_level());
      write_reg(REG_PEAK,    pick_level());
      if ($urandom_range(0, 3) == 0) begin
         idx  = CSR_INDEX_WIDTH'($urandom_range(32'(REG_SPARE_FIRST), 32'(REG_SPARE_LAST)));
         junk = 20'($urandom);
         write_reg(idx, junk);
      end
      csr_bus.valid <= 1'b0;
      settings_loaded++;
   endtask

   // held run then release run, steps scaled to the ramp lengths
   task automatic play_note();
      int held_len;
      int rel_len;
      int i;
      logic [63:0] span;
      if ($urandom_range(0, 1) == 1) t_now = $urandom;
      held_len = $urandom_range(1, 40);
      span = 64'(cfg_attack);
      span = (span + 64'(cfg_decay) + 64'd1) * 64'd3 / (64'd2 * 64'(held_len)) + 64'd1;
      for (i = 0; i < held_len; i++) begin
         send_tick(t_now, 1'b1, 1'b0, '0);
         t_now = t_now + $urandom_range(0, 32'(span));
      end
      rel_len = $urandom_range(0, 30);
      span = 64'(cfg_release);
      span = (span + 64'd1) * 64'd3 / (64'd2 * 64'(rel_len + 1)) + 64'd1;
      for (i = 0; i < rel_len; i++) begin
         send_tick(t_now, 1'b0, 1'b0, '0);
         t_now = t_now + $urandom_range(0, 32'(span));
      end
   endtask

   task automatic play_noise();
      int n;
      int i;
      n = $urandom_range(1, 8);
      for (i = 0; i < n; i++) send_tick($urandom, 1'($urandom_range(0, 1)), 1'b0, '0);
   endtask

   function automatic void add_write(input logic [CSR_INDEX_WIDTH-1:0] idx,
                                     input logic [19:0] value);
      stim_row_type row;
      row = '0;
      row.kind  = ROW_WRITE;
      row.index = idx;
      row.data  = value;
      stim_rows.push_back(row);
   endfunction

   function automatic void add_tick(input logic [31:0] t, input logic on);
      stim_row_type row;
      row = '0;
      row.kind = ROW_TICK;
      row.t    = t;
      row.on   = on;
      stim_rows.push_back(row);
   endfunction

   function automatic void add_tick_typed(input logic [31:0] t, input logic on,
                                          input logic [15:0] lvl, input logic act,
                                          input logic [PHASE_WIDTH-1:0] ph);
      stim_row_type row;
      row = '0;
      row.kind        = ROW_TICK;
      row.t           = t;
      row.on          = on;
      row.typed       = 1'b1;
      row.want.level  = lvl;
      row.want.active = act;
      row.want.phase  = ph;
      stim_rows.push_back(row);
   endfunction

   // response check against the oldest expectation
   always @(posedge clock) begin : rsp_check
      env_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (envelope_due.size() == 0) begin
            report_mismatch($sformatf("unexpected result level %0d active %0b phase %0d",
                                      rsp_bus.level, rsp_bus.active, rsp_bus.phase));
         end else begin
            want = envelope_due.pop_front();
            results_checked++;
            if (rsp_bus.level !== want.level || rsp_bus.active !== want.active ||
                rsp_bus.phase !== want.phase) begin
               report_mismatch($sformatf(
                  "result %0d got level %0d active %0b phase %0d, want %0d %0b %0d",
                  results_checked, rsp_bus.level, rsp_bus.active, rsp_bus.phase,
                  want.level, want.active, want.phase));
            end
         end
      end
   end

   // receiver: changing stall pattern, plus long hold-offs on demand
   initial begin : receiver
      int rx_cycle;
      int stall_left;
      rx_mode_type rx_mode;
      rx_cycle   = 0;
      stall_left = 0;
      rx_mode    = RX_STEADY;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_offs_done < hold_offs_asked) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
            hold_offs_done++;
         end else begin
            rx_cycle++;
            if (rx_cycle % 64 == 0) begin
               case ($urandom_range(0, 3))
                  0:       rx_mode = RX_STEADY;
                  1:       rx_mode = RX_COIN;
                  2:       rx_mode = RX_PERIODIC;
                  default: rx_mode = RX_BURSTY;
               endcase
            end
            case (rx_mode)
               RX_STEADY:   rsp_bus.ready <= 1'b1;
               RX_COIN:     rsp_bus.ready <= 1'($urandom_range(0, 1));
               RX_PERIODIC: rsp_bus.ready <= (rx_cycle % 4 == 0);
               default: begin
                  if (stall_left > 0) begin
                     rsp_bus.ready <= 1'b0;
                     stall_left--;
                  end else if ($urandom_range(0, 5) == 0) begin
                     stall_left = $urandom_range(1, 12);
                     rsp_bus.ready <= 1'b0;
                  end else begin
                     rsp_bus.ready <= 1'b1;
                  end
               end
            endcase
         end
      end
   end

   // main sequence
   initial begin : main
      int i;
      int ph;
      int phase_start;
      logic hold_asked;
      logic pause_asked;
      row_kind_type last_kind;

      ticks_sent = 0; writes_done = 0; hold_offs_asked = 0;
      settings_loaded = 0; pauses_done = 0; burst_left = 0;
      t_now = '0;

      req_bus.valid       = 1'b0;
      req_bus.sample_time = '0;
      req_bus.note_on     = 1'b0;
      csr_bus.valid       = 1'b0;
      csr_bus.index       = '0;
      csr_bus.data        = '0;

      cfg_attack  = 20'(RESET_ATTACK);
      cfg_decay   = 20'(RESET_DECAY);
      cfg_release = 20'(RESET_RELEASE);
      cfg_sustain = 16'(RESET_SUSTAIN);
      cfg_peak    = 16'(RESET_PEAK);
      note_t0     = '0;
      release_t0  = '0;
      start_seen  = 1'b0;
      end_seen    = 1'b0;
      silent      = 1'b1;

      // reset
      reset = 1'b1;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // defaults: note-off before any note, then a full note and its release
      add_tick_typed(32'd5,     1'b0, 16'd58982, 1'b0, PHASE_RELEASE);
      add_tick_typed(32'd100,   1'b1, 16'd0,     1'b1, PHASE_ATTACK);
      add_tick_typed(32'd541,   1'b1, 16'd64881, 1'b1, PHASE_ATTACK);
      add_tick_typed(32'd4951,  1'b1, 16'd58982, 1'b1, PHASE_DECAY);
      add_tick_typed(32'd4952,  1'b1, 16'd58982, 1'b1, PHASE_SUSTAIN);
      add_tick_typed(32'd10000, 1'b0, 16'd58982, 1'b1, PHASE_RELEASE);
      add_tick_typed(32'd14410, 1'b0, 16'd0,     1'b1, PHASE_RELEASE);
      add_tick_typed(32'd14411, 1'b0, 16'd0,     1'b0, PHASE_RELEASE);
      // sample time wrapping past the top
      add_tick_typed(32'hFFFF_FFF0, 1'b1, 16'd0, 1'b1, PHASE_ATTACK);
      add_tick(32'h0000_0010, 1'b1);
      add_tick_typed(32'hFFFF_FFFF, 1'b0, 16'd58982, 1'b1, PHASE_RELEASE);
      add_tick(32'h0000_0100, 1'b0);
      // zero-length segments, sustain above a zero peak
      add_write(REG_ATTACK,  20'd0);
      add_write(REG_DECAY,   20'd0);
      add_write(REG_RELEASE, 20'd0);
      add_write(REG_SUSTAIN, 20'd65535);
      add_write(REG_PEAK,    20'd0);
      add_tick_typed(32'd0, 1'b1, 16'd0,     1'b1, PHASE_ATTACK);
      add_tick_typed(32'd1, 1'b1, 16'd65535, 1'b1, PHASE_SUSTAIN);
      add_tick_typed(32'd2, 1'b0, 16'd0,     1'b1, PHASE_RELEASE);
      add_tick_typed(32'd3, 1'b0, 16'd0,     1'b0, PHASE_RELEASE);
      // longest ramps, zero sustain, writes past the map ignored
      add_write(REG_ATTACK,      20'hFFFFF);
      add_write(REG_DECAY,       20'hFFFFF);
      add_write(REG_RELEASE,     20'hFFFFF);
      add_write(REG_SUSTAIN,     20'd0);
      add_write(REG_PEAK,        20'd65535);
      add_write(REG_SPARE_FIRST, 20'hFFFFF);
      add_write(REG_SPARE_LAST,  20'h00000);
      add_tick_typed(32'd7,       1'b1, 16'd0,     1'b1, PHASE_ATTACK);
      add_tick_typed(32'd1048582, 1'b1, 16'd65535, 1'b1, PHASE_ATTACK);
      add_tick_typed(32'd2097157, 1'b1, 16'd0,     1'b1, PHASE_DECAY);
      add_tick(32'd1048682, 1'b1);
      add_tick_typed(32'h0020_0000, 1'b0, 16'd0, 1'b1, PHASE_RELEASE);
      add_tick_typed(32'h0040_0000, 1'b0, 16'd0, 1'b1, PHASE_RELEASE);
      // rising decay
      add_write(REG_ATTACK,  20'd10);
      add_write(REG_DECAY,   20'd100);
      add_write(REG_RELEASE, 20'd1000);
      add_write(REG_SUSTAIN, 20'd50000);
      add_write(REG_PEAK,    20'd1000);
      add_tick_typed(32'd0, 1'b1, 16'd0, 1'b1, PHASE_ATTACK);
      add_tick(32'd60, 1'b1);
      add_tick(32'd70, 1'b0);

      // walk the directed table
      last_kind = ROW_TICK;
      for (i = 0; i < stim_rows.size(); i++) begin
         if (stim_rows[i].kind == ROW_WRITE) begin
            if (last_kind == ROW_TICK) wait_drained();
            write_reg(stim_rows[i].index, stim_rows[i].data);
         end else begin
            if (last_kind == ROW_WRITE) csr_bus.valid <= 1'b0;
            send_tick(stim_rows[i].t, stim_rows[i].on, stim_rows[i].typed,
                      stim_rows[i].want);
         end
         last_kind = stim_rows[i].kind;
      end

      // random settings, mostly well-formed notes with some noise
      for (ph = 0; ph < RANDOM_SETTINGS; ph++) begin
         load_random_setting();
         phase_start = ticks_sent;
         hold_asked  = 1'b0;
         pause_asked = 1'b0;
         while (ticks_sent - phase_start < TICKS_PER_SETTING) begin
            if (ph % 6 == 3 && !hold_asked && ticks_sent - phase_start >= 60) begin
               hold_offs_asked++;
               hold_asked = 1'b1;
            end
            if (ph % 6 == 5 && !pause_asked && ticks_sent - phase_start >= 60) begin
               wait_drained();
               pauses_done++;
               pause_asked = 1'b1;
            end
            if ($urandom_range(0, 9) < 8) play_note();
            else play_noise();
         end
      end

      // let everything in flight come out
      wait_drained();

      $display("tb_top summary: %0d ticks, %0d results checked, %0d register writes",
               ticks_sent, results_checked, writes_done);
      $display("tb_top summary: %0d random settings, %0d long hold-offs, %0d drain pauses",
               settings_loaded, hold_offs_done, pauses_done);
      if (errors == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule

// File: filelist.f
design/aeg_pkg.sv
design/aeg_if.sv
design/aeg_csr.sv
design/aeg_div.sv
design/adsr_envelope_generator.sv
design/aeg_checker.sv
tb/tb_top.sv
